### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/afs_pkg.sv
`default_nettype none

package afs_pkg;

    localparam int FRAME_W  = 14;
    localparam int RUN_W    = 13;
    localparam int DEC_W    = 13;
    localparam int WIDE_W   = 48;
    localparam int PROD_W   = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP  = 3'd5;

    localparam logic [1:0] MODE_ONCE     = 2'd0;
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [7:0] FPS_RESET = 8'd30;

    typedef struct packed {
        logic        action;
        logic [15:0] tick_time;
        logic        hold;
        logic        ignore_time;
    } t_in;

    typedef struct packed {
        logic signed [FRAME_W-1:0] shown_frame;
        logic [DEC_W-1:0]          frames_to_decode;
        logic                      finished;
        logic                      reversed;
        logic [15:0]               loops_done;
    } t_out;

endpackage

`default_nettype wire

### rtl/animation_frame_sequencer.sv
// An input beat passes through S_MUL, S_TGT, S_CLAMP, S_FIN and S_EMIT; S_EMIT waits
// for the output to be free. A ping-pong turn adds S_DIV and S_SYNC after S_CLAMP for
// the bit-serial resync divider (one quotient bit a cycle). One item at a time: a new
// beat is taken only in S_IDLE. A restart or finished tick goes straight to S_EMIT.
// Reset (synchronous, active low): registers to 30/0/0/one-shot/0/1, playback restarted.
`default_nettype none

`include "assert_macros.svh"

module animation_frame_sequencer #(
    parameter int FRAME_BITS     = 12,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire afs_pkg::t_in                    i_in,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output afs_pkg::t_out                        o_out,
    input  wire                                  i_cfg_we,
    input  wire [afs_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [afs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int W      = afs_pkg::WIDE_W;
    localparam int FW     = afs_pkg::FRAME_W;
    localparam int RW     = afs_pkg::RUN_W;
    localparam int PW     = afs_pkg::PROD_W;
    localparam int DIV_W  = TIME_FRAC_BITS + 15;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam logic [RW-1:0] FRAME_MASK = RW'((2**FRAME_BITS) - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_TGT   = 8'b0000_0100,
        S_CLAMP = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_SYNC  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
        logic signed [31:0] res;
        if (v > W'(32'sh7fff_ffff)) begin
            res = 32'sh7fff_ffff;
        end else if (v < -W'(33'sh0_8000_0000)) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    t_state r_state;

    logic [7:0]  r_fps;
    logic [11:0] r_first;
    logic [11:0] r_last;
    logic [1:0]  r_mode;
    logic        r_rate;
    logic        r_skip;

    logic signed [31:0]   r_elapsed;
    logic signed [FW-1:0] r_cur;
    logic signed [FW-1:0] r_prev;
    logic [RW-1:0]        r_start;
    logic [RW-1:0]        r_stop;
    logic                 r_back;
    logic                 r_pend;
    logic [15:0]          r_loops;

    logic [15:0]          r_dt;
    logic                 r_hold;
    logic signed [FW-1:0] r_saved;
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0]  r_frame;
    logic [afs_pkg::DEC_W-1:0] r_decode;
    logic [DIV_W-1:0]     r_num;
    logic [7:0]           r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_kneg;

    logic          r_out_valid;
    afs_pkg::t_out r_out;

    logic [7:0]           fps_u;
    logic [RW-1:0]        rs_start;
    logic [RW-1:0]        rs_stop;
    logic signed [W-1:0]  start_w;
    logic signed [W-1:0]  stop_w;
    logic signed [W-1:0]  prev_w;
    logic signed [W-1:0]  cur_w;
    logic signed [PW-1:0] n_prod;
    logic [PW-1:0]        t_mag;
    logic [PW-1:0]        t_q;
    logic signed [W-1:0]  t_r;
    logic signed [W-1:0]  t_target;
    logic                 t_adv;
    logic signed [W-1:0]  n_frame_t;
    logic signed [W-1:0]  c_f1;
    logic                 c_hit;
    logic signed [15:0]   c_k;
    logic [15:0]          c_kmag;
    logic [8:0]           d_sh;
    logic                 d_ge;
    logic [8:0]           d_rem;
    logic signed [DIV_W:0] s_q;
    logic signed [W-1:0]  f_diff;
    logic signed [31:0]   f_elapsed;
    logic signed [W-1:0]  f_frame;
    logic signed [FW-1:0] f_prev;
    logic                 f_loop;
    logic                 accept;
    logic                 out_free;

    assign fps_u    = (r_fps == 8'd0) ? 8'd1 : r_fps;
    assign rs_start = {1'b0, r_first} & FRAME_MASK;
    assign rs_stop  = {1'b0, r_last} & FRAME_MASK;
    assign start_w  = W'({1'b0, r_start});
    assign stop_w   = W'({1'b0, r_stop});
    assign prev_w   = W'(r_prev);
    assign cur_w    = W'(r_cur);
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_prod = PW'(r_elapsed) * PW'(signed'({1'b0, fps_u}))
                 + (PW'(1) << (TIME_FRAC_BITS - 1));
    end

    always_comb begin
        t_mag    = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
        t_q      = t_mag >> TIME_FRAC_BITS;
        t_r      = r_prod[PW-1] ? -W'(t_q) : W'(t_q);
        t_target = r_back ? (start_w - W'(1) - t_r) : (start_w - W'(1) + t_r);
        t_adv    = r_back ? (t_target < prev_w) : (t_target > prev_w);
        n_frame_t = cur_w;
        if (t_adv) begin
            if (r_rate && r_skip) begin
                n_frame_t = t_target;
            end else begin
                n_frame_t = r_back ? (cur_w - W'(1)) : (cur_w + W'(1));
            end
        end
    end

    always_comb begin
        c_f1 = r_frame;
        if (r_back ? (r_frame > start_w) : (r_frame < start_w)) begin
            c_f1 = start_w;
        end
        c_hit = r_back ? (c_f1 <= stop_w) : (c_f1 >= stop_w);
        // after the turn the old stop is the new start
        if (!r_back) begin
            c_k = 16'(signed'({1'b0, r_stop})) - 16'(r_prev) - 16'sd1;
        end else begin
            c_k = 16'(r_prev) - 16'(signed'({1'b0, r_stop})) - 16'sd1;
        end
        c_kmag = c_k[15] ? 16'(-c_k) : 16'(c_k);
    end

    always_comb begin
        d_sh  = {r_rem, r_num[DIV_W-1]};
        d_ge  = d_sh >= 9'(fps_u);
        d_rem = d_ge ? (d_sh - 9'(fps_u)) : d_sh;
        s_q   = r_kneg ? -signed'({1'b0, r_num}) : signed'({1'b0, r_num});
    end

    always_comb begin
        if (!r_back) begin
            f_diff = (prev_w >= start_w) ? (r_frame - prev_w) : W'(1);
        end else begin
            f_diff = (prev_w <= start_w) ? (prev_w - r_frame) : W'(1);
        end
        f_elapsed = r_elapsed;
        f_frame   = r_frame;
        if (r_hold) begin
            f_frame   = W'(r_saved);
            f_elapsed = sat32(W'(r_elapsed) - W'(r_dt));
            f_diff    = '0;
        end
        f_prev = (f_diff > 0) ? f_frame[FW-1:0] : r_prev;
        f_loop = (f_elapsed == 32'sd0) && (r_mode == afs_pkg::MODE_LOOP);
        if (f_loop) begin
            f_prev  = -FW'(1);
            f_frame = -W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fps       <= afs_pkg::FPS_RESET;
            r_first     <= '0;
            r_last      <= '0;
            r_mode      <= afs_pkg::MODE_ONCE;
            r_rate      <= 1'b0;
            r_skip      <= 1'b1;
            r_elapsed   <= '0;
            r_start     <= '0;
            r_stop      <= '0;
            r_cur       <= -FW'(1);
            r_prev      <= -FW'(99);
            r_back      <= 1'b0;
            r_pend      <= 1'b0;
            r_loops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    afs_pkg::REG_FPS:   r_fps   <= i_cfg_data[7:0];
                    afs_pkg::REG_FIRST: r_first <= i_cfg_data;
                    afs_pkg::REG_LAST:  r_last  <= i_cfg_data;
                    afs_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                    afs_pkg::REG_RATE:  r_rate  <= i_cfg_data[0];
                    afs_pkg::REG_SKIP:  r_skip  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_decode <= '0;
                        if (i_in.action) begin
                            r_elapsed <= '0;
                            r_start   <= rs_start;
                            r_stop    <= rs_stop;
                            r_cur     <= FW'({1'b0, rs_start}) - FW'(1);
                            r_prev    <= -FW'(99);
                            r_back    <= 1'b0;
                            r_pend    <= 1'b0;
                            r_loops   <= '0;
                            r_state   <= S_EMIT;
                        end else if (r_pend) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_dt      <= i_in.ignore_time ? 16'd0 : i_in.tick_time;
                            r_hold    <= i_in.hold;
                            r_elapsed <= sat32(W'(r_elapsed)
                                         + W'(i_in.ignore_time ? 16'd0 : i_in.tick_time));
                            r_state   <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_TGT;
                end
                S_TGT: begin
                    r_saved <= r_cur;
                    r_frame <= n_frame_t;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (!c_hit) begin
                        r_frame <= c_f1;
                        r_state <= S_FIN;
                    end else if (r_mode == afs_pkg::MODE_LOOP) begin
                        r_frame   <= stop_w;
                        r_elapsed <= '0;
                        r_state   <= S_FIN;
                    end else if (r_mode == afs_pkg::MODE_PINGPONG) begin
                        r_back  <= !r_back;
                        r_frame <= prev_w;
                        r_prev  <= FW'({1'b0, r_stop});
                        r_stop  <= r_start;
                        r_start <= r_stop;
                        r_kneg  <= c_k[15];
                        r_num   <= (DIV_W'(c_kmag) << TIME_FRAC_BITS)
                                   + DIV_W'(fps_u[7:1]);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_frame <= r_back ? (stop_w + W'(1)) : stop_w;
                        r_prev  <= r_back ? FW'(stop_w + W'(1)) : FW'(stop_w);
                        r_pend  <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[DIV_W-2:0], d_ge};
                    r_rem <= d_rem[7:0];
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= S_SYNC;
                    end
                end
                S_SYNC: begin
                    r_elapsed <= sat32(W'(s_q));
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    r_elapsed <= f_elapsed;
                    r_prev    <= f_prev;
                    r_cur     <= f_frame[FW-1:0];
                    r_decode  <= (f_diff > 0) ? f_diff[afs_pkg::DEC_W-1:0] : '0;
                    if (f_loop) begin
                        r_loops <= r_loops + 16'd1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out.shown_frame      <= r_cur;
                        r_out.frames_to_decode <= r_decode;
                        r_out.finished         <= r_pend;
                        r_out.reversed         <= r_back;
                        r_out.loops_done       <= r_loops;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AFS_ASSERT_NXT(a_tick_starts_mul,
        accept && !i_in.action && !r_pend, r_state == S_MUL)
    `AFS_ASSERT_IMP(a_div_count_bound, r_state == S_DIV, r_cnt <= CNT_W'(DIV_W - 1))
    `AFS_ASSERT_NXT(a_emit_loads_out, r_state == S_EMIT && out_free,
        o_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire
